// ===== hdl/swom_pkg.sv =====
// Shared types, constants and helpers of the sliding window outlier mean block.
// No dependencies; imported by the top level.
package swom_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int SAMPLE_BITS_DEFAULT = 32;
    localparam int LIMIT_W             = 5;
    localparam int DIV_STEPS           = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 5'd16;
    localparam logic               REG_WINDOW_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP_CHK,
        ST_DROP_SUB,
        ST_APPEND,
        ST_DIV_RAW,
        ST_P1_DIFF,
        ST_P1_SQ,
        ST_P1_ACC,
        ST_DIV_VAR,
        ST_SQRT,
        ST_P2_DIFF,
        ST_P2_GAP,
        ST_DIV_CLIP,
        ST_DONE
    } state_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [63:0] abs_diff(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/sliding_window_outlier_mean.sv =====
// Top level of the sliding window outlier mean block: sequencer, shared divider,
// root unit and window store. Depends on swom_pkg and swom_ram.
//
// Each measurement beat drops the oldest window entries until fewer than
// window_limit remain (limit 0 acts as 1, limits above the depth act as the
// depth), appends the new one and returns one beat with the entry count, the
// raw mean and the mean of the entries within one standard deviation of it.
// Each measurement runs up to three passes of a bit-serial restoring divider, a
// 32-step integer square root, and two passes over the window store through
// its single registered read port; the third divider pass is skipped when no
// entry lies within the deviation. The input is not ready while a measurement
// is in work; a finished result waits in the output register, and the next
// measurement is taken meanwhile. The store needs no clearing after reset.
// window_limit resets to 16.
module sliding_window_outlier_mean #(
    parameter int WINDOW_DEPTH = swom_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS  = swom_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] measurement
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [4:0] entry_count, [36:5] raw_mean, [68:37] clipped_mean
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import swom_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [63:0]      SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_SUM  = (IDX_W + 1)'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(WINDOW_DEPTH);
    localparam logic [5:0]       DIV_LAST   = 6'(DIV_STEPS - 1);

    // control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [IDX_W-1:0]     oldest_reg, oldest_next;
    logic [63:0]          total_reg, total_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // datapath
    logic [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [63:0]          raw_reg, raw_next;
    logic [63:0]          diff_reg, diff_next;
    logic [63:0]          prod_reg, prod_next;
    logic                 ovf_reg, ovf_next;
    logic [63:0]          sq_reg, sq_next;
    logic [63:0]          dq_reg, dq_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     den_reg, den_next;
    logic [5:0]           step_reg, step_next;
    logic [63:0]          rt_x_reg, rt_x_next;
    logic [63:0]          rt_res_reg, rt_res_next;
    logic [63:0]          rt_bit_reg, rt_bit_next;
    logic [63:0]          csum_reg, csum_next;
    logic [CNT_W-1:0]     ccount_reg, ccount_next;
    logic [71:0]          m_tdata_reg, m_tdata_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [63:0]            rd_wide;

    logic [63:0]            meas_wide;
    logic [SAMPLE_BITS-1:0] samp_in;
    logic [CNT_W-1:0]       lim_eff;
    logic [IDX_W:0]         app_sum;
    logic [IDX_W-1:0]       ptr_inc;
    logic [IDX_W-1:0]       oldest_inc;

    logic [CNT_W:0]         div_trial;
    logic                   div_ge;
    logic [CNT_W-1:0]       div_rem_step;
    logic [63:0]            div_q_step;
    logic                   div_last;

    logic [63:0]            rt_sum;
    logic                   rt_ge;
    logic [63:0]            rt_x_step;
    logic [63:0]            rt_res_step;
    logic                   rt_last;

    logic [31:0]            sq_op;
    logic [63:0]            acc_sum;
    logic [63:0]            raw_sat;
    logic [63:0]            cm_sat;
    logic [63:0]            held_wide;
    logic                   cfg_wr;

    assign meas_wide = 64'(s_tdata);
    assign samp_in   = (meas_wide > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                                : meas_wide[SAMPLE_BITS-1:0];

    assign lim_eff = (limit_reg == '0)               ? CNT_W'(1) :
                     (int'(limit_reg) > WINDOW_DEPTH) ? DEPTH_CNT :
                                                        CNT_W'(limit_reg);

    assign app_sum    = (IDX_W + 1)'(oldest_reg) + (IDX_W + 1)'(held_reg);
    assign ram_waddr  = (app_sum >= DEPTH_SUM) ? IDX_W'(app_sum - DEPTH_SUM) : IDX_W'(app_sum);
    assign ptr_inc    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
    assign oldest_inc = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + IDX_W'(1);

    assign ram_we    = (state_reg == ST_APPEND);
    assign ram_raddr = (state_reg == ST_DROP_CHK) ? oldest_reg : ptr_reg;
    assign rd_wide   = 64'(ram_rdata);

    // shared restoring divider, one quotient bit per cycle
    assign div_trial    = {rem_reg, dq_reg[63]};
    assign div_ge       = div_trial >= {1'b0, den_reg};
    assign div_rem_step = div_ge ? CNT_W'(div_trial - {1'b0, den_reg}) : CNT_W'(div_trial);
    assign div_q_step   = {dq_reg[62:0], div_ge};
    assign div_last     = (step_reg == DIV_LAST);

    // integer square root, two radicand bits per cycle
    assign rt_sum      = rt_res_reg + rt_bit_reg;
    assign rt_ge       = rt_x_reg >= rt_sum;
    assign rt_x_step   = rt_ge ? (rt_x_reg - rt_sum) : rt_x_reg;
    assign rt_res_step = rt_ge ? ((rt_res_reg >> 1) + rt_bit_reg) : (rt_res_reg >> 1);
    assign rt_last     = (rt_bit_reg == 64'd1);

    assign sq_op     = diff_reg[31:0];
    assign acc_sum   = sat_add(sq_reg, ovf_reg ? {64{1'b1}} : prod_reg);
    assign raw_sat   = (raw_reg > SAMPLE_MAX) ? SAMPLE_MAX : raw_reg;
    assign cm_sat    = (dq_reg > SAMPLE_MAX) ? SAMPLE_MAX : dq_reg;
    assign held_wide = 64'(held_reg);

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LIMIT) ? 32'(limit_reg) : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    swom_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (samp_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        oldest_next   = oldest_reg;
        total_next    = total_reg;
        limit_next    = limit_reg;
        m_tvalid_next = m_tvalid_reg;
        samp_next     = samp_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        raw_next      = raw_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        ovf_next      = ovf_reg;
        sq_next       = sq_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        step_next     = step_reg;
        rt_x_next     = rt_x_reg;
        rt_res_next   = rt_res_reg;
        rt_bit_next   = rt_bit_reg;
        csum_next     = csum_reg;
        ccount_next   = ccount_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_wr && (paddr[2] == REG_WINDOW_LIMIT)) begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    samp_next  = samp_in;
                    state_next = ST_DROP_CHK;
                end
            end
            ST_DROP_CHK: begin
                state_next = (held_reg >= lim_eff) ? ST_DROP_SUB : ST_APPEND;
            end
            ST_DROP_SUB: begin
                total_next  = (total_reg > rd_wide) ? (total_reg - rd_wide) : 64'd0;
                oldest_next = oldest_inc;
                held_next   = held_reg - CNT_W'(1);
                state_next  = ST_DROP_CHK;
            end
            ST_APPEND: begin
                total_next = sat_add(total_reg, 64'(samp_reg));
                held_next  = held_reg + CNT_W'(1);
                dq_next    = total_next;
                den_next   = held_next;
                rem_next   = '0;
                step_next  = '0;
                ptr_next   = oldest_reg;
                state_next = ST_DIV_RAW;
            end
            ST_DIV_RAW: begin
                dq_next   = div_q_step;
                rem_next  = div_rem_step;
                step_next = step_reg + 6'd1;
                if (div_last) begin
                    raw_next   = div_q_step;
                    sq_next    = '0;
                    k_next     = '0;
                    state_next = ST_P1_DIFF;
                end
            end
            ST_P1_DIFF: begin
                diff_next  = abs_diff(rd_wide, raw_reg);
                ptr_next   = ptr_inc;
                k_next     = k_reg + CNT_W'(1);
                state_next = ST_P1_SQ;
            end
            ST_P1_SQ: begin
                prod_next  = 64'(sq_op) * 64'(sq_op);
                ovf_next   = |diff_reg[63:32];
                state_next = ST_P1_ACC;
            end
            ST_P1_ACC: begin
                sq_next = acc_sum;
                if (k_reg == held_reg) begin
                    dq_next    = acc_sum;
                    den_next   = held_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    ptr_next   = oldest_reg;
                    state_next = ST_DIV_VAR;
                end else begin
                    state_next = ST_P1_DIFF;
                end
            end
            ST_DIV_VAR: begin
                dq_next   = div_q_step;
                rem_next  = div_rem_step;
                step_next = step_reg + 6'd1;
                if (div_last) begin
                    rt_x_next   = div_q_step;
                    rt_res_next = '0;
                    rt_bit_next = 64'd1 << 62;
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rt_x_next   = rt_x_step;
                rt_res_next = rt_res_step;
                rt_bit_next = rt_bit_reg >> 2;
                if (rt_last) begin
                    csum_next   = '0;
                    ccount_next = '0;
                    k_next      = '0;
                    state_next  = ST_P2_DIFF;
                end
            end
            ST_P2_DIFF: begin
                if (abs_diff(rd_wide, raw_reg) <= rt_res_reg) begin
                    csum_next   = sat_add(csum_reg, rd_wide);
                    ccount_next = ccount_reg + CNT_W'(1);
                end
                ptr_next   = ptr_inc;
                k_next     = k_reg + CNT_W'(1);
                state_next = ST_P2_GAP;
            end
            ST_P2_GAP: begin
                if (k_reg == held_reg) begin
                    if (ccount_reg != '0) begin
                        dq_next    = csum_reg;
                        den_next   = ccount_reg;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV_CLIP;
                    end else begin
                        dq_next    = '0;
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_P2_DIFF;
                end
            end
            ST_DIV_CLIP: begin
                dq_next   = div_q_step;
                rem_next  = div_rem_step;
                step_next = step_reg + 6'd1;
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {3'd0, cm_sat[31:0], raw_sat[31:0], held_wide[4:0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_reg     <= '0;
            oldest_reg   <= '0;
            total_reg    <= '0;
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            oldest_reg   <= oldest_next;
            total_reg    <= total_next;
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg    <= samp_next;
        ptr_reg     <= ptr_next;
        k_reg       <= k_next;
        raw_reg     <= raw_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        ovf_reg     <= ovf_next;
        sq_reg      <= sq_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        step_reg    <= step_next;
        rt_x_reg    <= rt_x_next;
        rt_res_reg  <= rt_res_next;
        rt_bit_reg  <= rt_bit_next;
        csum_reg    <= csum_next;
        ccount_reg  <= ccount_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= DEPTH_CNT)
        else $error("window count exceeds depth");

    a_oldest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg <= LAST_IDX)
        else $error("oldest index out of range");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_RAW || state_reg == ST_DIV_VAR || state_reg == ST_DIV_CLIP)
        |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_done_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (held_reg != '0))
        else $error("result with empty window");

    a_root_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT)
        |-> ((rt_bit_reg != '0) && ((rt_bit_reg & (rt_bit_reg - 64'd1)) == '0)))
        else $error("root trial bit not a single bit");
`endif

endmodule

// ===== hdl/swom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
